@@ design/ipv4_header_receive_checker_unit_macros.svh @@
// ---------------------------------------------------------------------------
// IPv4 header receive checker assertion macros
// Shared property forms for the checker.
// ---------------------------------------------------------------------------
`ifndef IPV4_HEADER_RECEIVE_CHECKER_UNIT_MACROS_SVH
`define IPV4_HEADER_RECEIVE_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define IHRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihrc assertion failed");

// next-cycle implication, disabled in reset
`define IHRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihrc assertion failed");

`endif

@@ design/ihrc_pkg.sv @@
// ---------------------------------------------------------------------------
// IPv4 header receive checker package
// Word types, verdict codes and the ones'-complement fold.
// ---------------------------------------------------------------------------
package ihrc_pkg;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  verdict;
      logic [3:0]  header_words;
      logic [31:0] payload_word;
      logic        payload_last;
   } rsp_word_type;

   localparam logic       KIND_VERDICT = 1'b0;
   localparam logic       KIND_PAYLOAD = 1'b1;

   localparam logic [2:0] VERDICT_OK       = 3'd0;
   localparam logic [2:0] VERDICT_CHECKSUM = 3'd1;
   localparam logic [2:0] VERDICT_TTL      = 3'd2;
   localparam logic [2:0] VERDICT_VERSION  = 3'd3;
   localparam logic [2:0] VERDICT_HDR_LEN  = 3'd4;
   localparam logic [2:0] VERDICT_DEST     = 3'd5;

   localparam logic [3:0]  IHL_MIN      = 4'd5;
   localparam logic [3:0]  VERSION_IPV4 = 4'd4;
   localparam logic [15:0] SUM_GOOD     = 16'hffff;

   localparam logic [3:0] IDX_VERSION = 4'd0;
   localparam logic [3:0] IDX_TTL     = 4'd2;
   localparam logic [3:0] IDX_DEST    = 4'd4;

   function automatic logic [15:0] fold16(input logic [15:0] acc, input logic [15:0] half);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, half};
      fold16 = s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

@@ design/ipv4_header_receive_checker_unit.sv @@
// ---------------------------------------------------------------------------
// IPv4 header receive checker
// A result word, if any, is valid in the cycle after its input is accepted.
// Throughput: one input word per cycle; the result register is the only stage
// and the input is taken whenever it is empty or being drained.
// Reset: synchronous, active high; clears the header state, the packet phase,
// the local address and the result valid.
// ---------------------------------------------------------------------------
module ipv4_header_receive_checker_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ihrc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ihrc_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata
);
   import ihrc_pkg::*;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_PAYLOAD,
      PHASE_DROP
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [3:0]   word_count_ff, word_count_in;
   logic [15:0]  sum_ff, sum_in;
   logic [3:0]   ihl_ff, ihl_in;
   logic [3:0]   version_ff, version_in;
   logic         ttl_zero_ff, ttl_zero_in;
   logic         dest_miss_ff, dest_miss_in;
   logic [31:0]  local_addr_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic         accept;
   logic         emit;
   logic [15:0]  sum_hi;
   logic [15:0]  sum_new;
   logic [3:0]   ihl_cur;
   logic [3:0]   version_cur;
   logic         ttl_cur;
   logic         dest_cur;
   logic [3:0]   span;
   logic         done;
   logic [2:0]   verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      version_cur = (word_count_ff == IDX_VERSION) ? req_data.word[31:28] : version_ff;
      ihl_cur     = (word_count_ff == IDX_VERSION) ? req_data.word[27:24] : ihl_ff;
      sum_hi      = fold16(sum_ff, req_data.word[31:16]);
      sum_new     = fold16(sum_hi, req_data.word[15:0]);
      ttl_cur     = (word_count_ff == IDX_TTL) ? (req_data.word[31:24] == 8'd0) : ttl_zero_ff;
      dest_cur    = (word_count_ff == IDX_DEST) ? (req_data.word != local_addr_ff)
                                                 : dest_miss_ff;
      span        = (ihl_cur < IHL_MIN) ? IHL_MIN : ihl_cur;
      done        = ({1'b0, word_count_ff} + 5'd1) >= {1'b0, span};

      if (sum_new != SUM_GOOD) begin
         verdict = VERDICT_CHECKSUM;
      end else if (ttl_cur) begin
         verdict = VERDICT_TTL;
      end else if (version_cur != VERSION_IPV4) begin
         verdict = VERDICT_VERSION;
      end else if ((ihl_cur < IHL_MIN) || !done) begin
         verdict = VERDICT_HDR_LEN;
      end else if (dest_cur) begin
         verdict = VERDICT_DEST;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      word_count_in = word_count_ff;
      sum_in        = sum_ff;
      ihl_in        = ihl_ff;
      version_in    = version_ff;
      ttl_zero_in   = ttl_zero_ff;
      dest_miss_in  = dest_miss_ff;
      emit          = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         case (phase_ff)
            PHASE_PAYLOAD: begin
               emit                     = 1'b1;
               rsp_data_in.result_kind  = KIND_PAYLOAD;
               rsp_data_in.verdict      = VERDICT_OK;
               rsp_data_in.header_words = ihl_ff;
               rsp_data_in.payload_word = req_data.word;
               rsp_data_in.payload_last = req_data.last;
               if (req_data.last) begin
                  phase_in = PHASE_HEADER;
               end
            end
            PHASE_HEADER: begin
               ihl_in     = ihl_cur;
               version_in = version_cur;
               if (!done && !req_data.last) begin
                  word_count_in = word_count_ff + 4'd1;
                  sum_in        = sum_new;
                  ttl_zero_in   = ttl_cur;
                  dest_miss_in  = dest_cur;
               end else begin
                  emit                     = 1'b1;
                  rsp_data_in.result_kind  = KIND_VERDICT;
                  rsp_data_in.verdict      = verdict;
                  rsp_data_in.header_words = ihl_cur;
                  rsp_data_in.payload_word = 32'd0;
                  rsp_data_in.payload_last = 1'b0;
                  word_count_in            = 4'd0;
                  sum_in                   = 16'd0;
                  version_in               = 4'd0;
                  ttl_zero_in              = 1'b0;
                  dest_miss_in             = 1'b0;
                  if (req_data.last) begin
                     phase_in = PHASE_HEADER;
                  end else if (verdict == VERDICT_OK) begin
                     phase_in = PHASE_PAYLOAD;
                  end else begin
                     phase_in = PHASE_DROP;
                  end
               end
            end
            default: begin
               if (req_data.last) begin
                  phase_in = PHASE_HEADER;
               end
            end
         endcase
         if (emit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         word_count_ff <= 4'd0;
         sum_ff        <= 16'd0;
         ihl_ff        <= 4'd0;
         version_ff    <= 4'd0;
         ttl_zero_ff   <= 1'b0;
         dest_miss_ff  <= 1'b0;
         local_addr_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         word_count_ff <= word_count_in;
         sum_ff        <= sum_in;
         ihl_ff        <= ihl_in;
         version_ff    <= version_in;
         ttl_zero_ff   <= ttl_zero_in;
         dest_miss_ff  <= dest_miss_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            local_addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ design/ihrc_checker.sv @@
// ---------------------------------------------------------------------------
// IPv4 header receive checker port assertions
// Watches the top level ports; bound to every instance of the top level.
// ---------------------------------------------------------------------------
`include "ipv4_header_receive_checker_unit_macros.svh"

module ihrc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ihrc_pkg::rsp_word_type rsp_data
);
   import ihrc_pkg::*;

   `IHRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `IHRC_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `IHRC_ASSERT_SAME(a_verdict_range, clock, reset, rsp_valid && (rsp_data.result_kind == KIND_VERDICT), (rsp_data.verdict <= VERDICT_DEST) && (rsp_data.payload_word == 32'd0) && !rsp_data.payload_last)
   `IHRC_ASSERT_SAME(a_payload_ok, clock, reset, rsp_valid && (rsp_data.result_kind == KIND_PAYLOAD), rsp_data.verdict == VERDICT_OK)

endmodule

bind ipv4_header_receive_checker_unit ihrc_checker u_ihrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
